// ===== design/pal_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pal_pkg
// Shared types and codes for the positional array list.
// ============================================================================
package pal_pkg;

   // Request operation codes.
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOCATE = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Cells per segment; the result chain is registered once per segment.
   localparam int SEG_CELLS = 8;

   // Control broadcast to every cell.
   typedef struct packed {
      mode_type    mode;
      logic [7:0]  position;
      logic [31:0] value;
      logic        insert_en;
      logic        delete_en;
   } cell_ctrl_type;

   // Result word travelling down the chain toward cell 0.
   typedef struct packed {
      logic        found;
      logic [31:0] data;
   } carry_type;

endpackage

// ===== design/pal_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pal_cell
// One list entry: local shift on insert/delete and a match tap on the chain.
// ============================================================================
module pal_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 9
) (
   input  logic                  clock,
   input  pal_pkg::cell_ctrl_type ctrl,
   input  logic [CMP_W-1:0]      count_ext,
   input  logic [31:0]           left_entry,
   input  logic [31:0]           right_entry,
   input  pal_pkg::carry_type    carry_in,
   output logic [31:0]           entry,
   output pal_pkg::carry_type    carry_out
);
   import pal_pkg::*;

   // 1-based slot number of this cell
   localparam logic [CMP_W-1:0] SLOT = CMP_W'(INDEX + 1);

   logic [31:0]      entry_ff;
   logic [31:0]      entry_in;
   logic [CMP_W-1:0] pos_ext;
   logic             live;
   logic             hit;
   logic [31:0]      payload;

   assign pos_ext = CMP_W'(ctrl.position);
   assign live    = (SLOT <= count_ext);

   always_comb begin
      hit     = 1'b0;
      payload = entry_ff;
      case (ctrl.mode)
         MODE_DELETE: begin
            hit = (SLOT == pos_ext);
         end
         MODE_LOCATE: begin
            hit     = live && (entry_ff == ctrl.value);
            payload = {24'd0, SLOT[7:0]};
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // lower cells override: first match wins
   always_comb begin
      if (hit) begin
         carry_out.found = 1'b1;
         carry_out.data  = payload;
      end else begin
         carry_out = carry_in;
      end
   end

   always_comb begin
      if (ctrl.insert_en && (SLOT == pos_ext)) begin
         entry_in = ctrl.value;
      end else if (ctrl.insert_en && (SLOT > pos_ext)) begin
         entry_in = left_entry;
      end else if (ctrl.delete_en && (SLOT >= pos_ext)) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== design/pal_segment.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pal_segment
// A run of cells with a register on the incoming result chain.
// ============================================================================
module pal_segment #(
   parameter int CELLS = 8,
   parameter int BASE  = 0,
   parameter int CMP_W = 9
) (
   input  logic                   clock,
   input  pal_pkg::cell_ctrl_type ctrl,
   input  logic [CMP_W-1:0]       count_ext,
   input  logic [31:0]            left_entry,
   input  logic [31:0]            right_entry,
   input  pal_pkg::carry_type     carry_in,
   output logic [31:0]            entry_low,
   output logic [31:0]            entry_high,
   output pal_pkg::carry_type     carry_out
);
   import pal_pkg::*;

   carry_type   carry_in_ff;
   carry_type   link [CELLS+1];
   logic [31:0] entries [CELLS];

   always_ff @(posedge clock) begin
      carry_in_ff <= carry_in;
   end

   assign link[CELLS] = carry_in_ff;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic [31:0] left_w;
      logic [31:0] right_w;

      if (k == 0) begin : g_lo
         assign left_w = left_entry;
      end else begin : g_lo_n
         assign left_w = entries[k-1];
      end

      if (k == CELLS - 1) begin : g_hi
         assign right_w = right_entry;
      end else begin : g_hi_n
         assign right_w = entries[k+1];
      end

      pal_cell #(
         .INDEX (BASE + k),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count_ext   (count_ext),
         .left_entry  (left_w),
         .right_entry (right_w),
         .carry_in    (link[k+1]),
         .entry       (entries[k]),
         .carry_out   (link[k])
      );
   end

   assign entry_low  = entries[0];
   assign entry_high = entries[CELLS-1];
   assign carry_out  = link[0];

endmodule

// ===== design/positional_array_list_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// positional_array_list_top
// Ordered list of signed 32-bit words with insert, delete and locate.
// ============================================================================
// Usage:
//  - Request channel: drive req_mode/req_position/req_value and raise start.
//    A transaction is taken at the clock edge where start is high and busy
//    is low. Modes: insert at a 1-based position, delete at a position,
//    locate the first entry equal to req_value.
//  - Response channel: rsp_strobe is high for exactly one cycle with status,
//    removed value, found position and the list length after the operation.
//    The receiver cannot stall; it must take the response in that cycle.
//  - busy drops in the strobe cycle, so the next request may be taken there;
//    a new request is not taken while an earlier one is still in its scan.
//  - The result chain sets the scan length: each cell taps a match (locate)
//    or the addressed entry (delete) onto a chain running toward cell 0,
//    registered once per segment of 8 cells, with NSEG = ceil(CAPACITY / 8)
//    segments. The shift of insert/delete is applied in the final scan cycle.
//  - Reset (synchronous, active high) empties the list and returns to idle.
//    Store contents are not cleared; only entries below the length are read.
// ============================================================================
module positional_array_list_top #(
   parameter int CAPACITY = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic [7:0]         rsp_found_position,
   output logic [7:0]         rsp_list_length
);
   import pal_pkg::*;

   // number of segments and the last segment's size
   localparam int NSEG      = (CAPACITY + SEG_CELLS - 1) / SEG_CELLS;
   localparam int LAST_SIZE = CAPACITY - SEG_CELLS * (NSEG - 1);
   // length counter holds 0..CAPACITY
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   // compare width covers both the 8-bit position and the length, plus one
   localparam int CMP_W     = ((CNT_W > 8) ? CNT_W : 8) + 1;
   localparam int SCAN_W    = (NSEG > 1) ? $clog2(NSEG) : 1;
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NSEG - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // latched request
   mode_type          mode_ff;
   logic [7:0]        position_ff;
   logic [31:0]       value_ff;

   // response registers
   logic              strobe_ff;
   status_type        status_ff;
   status_type        status_in;
   logic [31:0]       removed_ff;
   logic [31:0]       removed_in;
   logic [7:0]        found_ff;
   logic [7:0]        found_in;
   logic [7:0]        length_ff;

   logic              accept;
   logic              finish;
   logic              ins_ok;
   logic              del_ok;
   logic              ins_range;
   logic              del_range;
   logic              list_full;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  len_ext;

   cell_ctrl_type     ctrl;
   logic [31:0]       seg_low   [NSEG];
   logic [31:0]       seg_high  [NSEG];
   carry_type         seg_carry [NSEG];

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;
   assign finish = (state_ff == ST_SCAN) && (scan_ff == SCAN_LAST);

   // ---------------------------------------------------------------------
   // Range and capacity checks against the current length
   // ---------------------------------------------------------------------
   assign pos_ext   = CMP_W'(position_ff);
   assign cnt_ext   = CMP_W'(count_ff);
   assign ins_range = (pos_ext == '0) || (pos_ext > (cnt_ext + 1'b1));
   assign del_range = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign list_full = (count_ff == CNT_FULL);

   always_comb begin
      status_in  = STATUS_RANGE;
      removed_in = 32'd0;
      found_in   = 8'd0;
      count_in   = count_ff;
      ins_ok     = 1'b0;
      del_ok     = 1'b0;
      case (mode_ff)
         MODE_INSERT: begin
            if (ins_range) begin
               status_in = STATUS_RANGE;
            end else if (list_full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_OK;
               ins_ok    = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         MODE_DELETE: begin
            if (del_range) begin
               status_in = STATUS_RANGE;
            end else begin
               status_in  = STATUS_OK;
               del_ok     = 1'b1;
               removed_in = seg_carry[0].data;
               count_in   = count_ff - 1'b1;
            end
         end
         MODE_LOCATE: begin
            status_in = STATUS_OK;
            if (seg_carry[0].found) begin
               found_in = seg_carry[0].data[7:0];
            end
         end
         default: begin
            status_in = STATUS_RANGE;
         end
      endcase
   end

   assign len_ext = CMP_W'(count_in);

   // broadcast to the cells; the shift is applied on the finishing edge
   always_comb begin
      ctrl.mode      = mode_ff;
      ctrl.position  = position_ff;
      ctrl.value     = value_ff;
      ctrl.insert_en = finish && ins_ok;
      ctrl.delete_en = finish && del_ok;
   end

   // ---------------------------------------------------------------------
   // Cell chain, one segment per 8 entries
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < NSEG; g++) begin : g_seg
      localparam int SIZE = (g == NSEG - 1) ? LAST_SIZE : SEG_CELLS;
      logic [31:0] left_w;
      logic [31:0] right_w;
      carry_type   carry_w;

      if (g == 0) begin : g_first
         assign left_w = 32'd0;
      end else begin : g_first_n
         assign left_w = seg_high[g-1];
      end

      if (g == NSEG - 1) begin : g_last
         assign right_w = 32'd0;
         assign carry_w = '0;
      end else begin : g_last_n
         assign right_w = seg_low[g+1];
         assign carry_w = seg_carry[g+1];
      end

      pal_segment #(
         .CELLS (SIZE),
         .BASE  (g * SEG_CELLS),
         .CMP_W (CMP_W)
      ) u_seg (
         .clock       (clock),
         .ctrl        (ctrl),
         .count_ext   (cnt_ext),
         .left_entry  (left_w),
         .right_entry (right_w),
         .carry_in    (carry_w),
         .entry_low   (seg_low[g]),
         .entry_high  (seg_high[g]),
         .carry_out   (seg_carry[g])
      );
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= finish;
         if (finish) begin
            count_ff <= count_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  scan_ff  <= '0;
               end
            end
            ST_SCAN: begin
               if (finish) begin
                  state_ff <= ST_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= mode_type'(req_mode);
         position_ff <= req_position;
         value_ff    <= req_value;
      end
      if (finish) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         found_ff   <= found_in;
         length_ff  <= len_ext[7:0];
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_removed_value  = removed_ff;
   assign rsp_found_position = found_ff;
   assign rsp_list_length    = length_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("list length above capacity");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + 1'b1) ||
                        (count_ff == $past(count_ff) - 1'b1))
      else $error("list length changed by more than one");

   a_len_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(finish)) |-> (count_ff == $past(count_ff)))
      else $error("list length changed outside a finishing cycle");

   a_strobe_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_SCAN))
      else $error("response strobe without a scan");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transaction accepted but block not busy");

endmodule
